@@ hw/rtl/msk_pkg.sv @@
package msk_pkg;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic                    end_of_run;
        logic                    truncated;
    } out_item_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_PRIME,
        S_MERGE,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // input request accepted
        logic start;    // set up first merge pass
        logic prime;    // fetch run heads
        logic merge;    // one merge step
        logic out_run;  // stream sorted keys
        logic done;     // set finished, clear count and flag
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic trivial;   // at most one key held
        logic run_end;   // this step writes the last entry of the run
        logic pass_end;  // the run ends at the last held key
        logic sorted;    // next run width covers the whole set
        logic out_done;  // last result taken
    } dp_stat_t;

endpackage

@@ hw/rtl/msk_ram.sv @@
module msk_ram import msk_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re0,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic                     re1,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re0)
        begin
            rdata0 <= mem[raddr0];
        end
        if (re1)
        begin
            rdata1 <= mem[raddr1];
        end
    end

endmodule

@@ hw/rtl/msk_ctrl.sv @@
module msk_ctrl import msk_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = stat.trivial ? S_OUT : S_PRIME;
            end
            S_PRIME:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (stat.run_end)
                begin
                    state_next = (stat.pass_end && stat.sorted) ? S_OUT : S_PRIME;
                end
            end
            S_OUT:
            begin
                if (stat.out_done)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_START:
            begin
                cmd.start = 1'b1;
            end
            S_PRIME:
            begin
                cmd.prime = 1'b1;
            end
            S_MERGE:
            begin
                cmd.merge = 1'b1;
            end
            S_OUT:
            begin
                cmd.out_run = 1'b1;
                cmd.done    = stat.out_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/msk_dp.sv @@
module msk_dp import msk_pkg::*; #(
    parameter int MAX_KEYS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    input  logic [KEY_W-1:0] in_key,
    input  logic       out_ready,
    output logic       out_valid,
    output out_item_t  out_item
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int SW = CW + 2;

    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          ovf_reg,   ovf_next;
    logic [CW:0]   width_reg, width_next;
    logic [CW-1:0] lo_reg,    lo_next;
    logic [CW-1:0] mid_reg,   mid_next;
    logic [CW-1:0] hi_reg,    hi_next;
    logic [CW-1:0] a_reg,     a_next;
    logic [CW-1:0] b_reg,     b_next;
    logic [CW-1:0] k_reg,     k_next;
    logic          src_reg,   src_next;
    logic [CW-1:0] i_reg,     i_next;
    logic          dv_reg,    dv_next;
    logic          dv_last_reg, dv_last_next;
    logic          ov_reg,    ov_next;
    logic [KEY_W-1:0] out_key_reg;
    logic          out_last_reg;

    logic [SW-1:0] lo_w, width_w, n_w, mid_sum, hi_sum;
    logic [CW-1:0] mid_calc, hi_calc;
    logic [KEY_W-1:0] b0_rd0, b0_rd1, b1_rd0, b1_rd1;
    logic [KEY_W-1:0] head_a, head_b, merge_data;
    logic          a_ok, b_ok, take_a;
    logic [CW-1:0] a_step, b_step;
    logic          load_wr, fetch, move;
    logic [CW-1:0] rd_addr0, rd_addr1;
    logic          re0, re1;
    logic          b0_we, b1_we;
    logic [CW-1:0] b0_waddr;
    logic [KEY_W-1:0] b0_wdata;

    assign lo_w     = SW'(lo_reg);
    assign width_w  = SW'(width_reg);
    assign n_w      = SW'(cnt_reg);
    assign mid_sum  = lo_w + width_w;
    assign hi_sum   = lo_w + (width_w << 1);
    assign mid_calc = (mid_sum > n_w) ? cnt_reg : mid_sum[CW-1:0];
    assign hi_calc  = (hi_sum > n_w) ? cnt_reg : hi_sum[CW-1:0];

    assign head_a = src_reg ? b1_rd0 : b0_rd0;
    assign head_b = src_reg ? b1_rd1 : b0_rd1;

    // exhausted run never wins; ties go to the second run
    assign a_ok       = a_reg < mid_reg;
    assign b_ok       = b_reg < hi_reg;
    assign take_a     = a_ok && (!b_ok || ($signed(head_a) < $signed(head_b)));
    assign merge_data = take_a ? head_a : head_b;
    assign a_step     = take_a ? a_reg + CW'(1) : a_reg;
    assign b_step     = take_a ? b_reg : b_reg + CW'(1);

    assign load_wr = cmd.load && (cnt_reg < CW'(MAX_KEYS));

    // output: RAM read register, then output register
    assign move  = dv_reg && (!ov_reg || out_ready);
    assign fetch = cmd.out_run && (i_reg < cnt_reg) && (!dv_reg || move);

    assign rd_addr0 = cmd.prime ? lo_reg : (cmd.merge ? a_step : i_reg);
    assign rd_addr1 = cmd.prime ? mid_calc : b_step;
    assign re0      = cmd.prime || cmd.merge || fetch;
    assign re1      = cmd.prime || cmd.merge;

    assign b0_we    = load_wr || (cmd.merge && src_reg);
    assign b0_waddr = cmd.merge ? k_reg : cnt_reg;
    assign b0_wdata = cmd.merge ? merge_data : in_key;
    assign b1_we    = cmd.merge && !src_reg;

    msk_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_bank0 (
        .clk    (clk),
        .we     (b0_we),
        .waddr  (b0_waddr[AW-1:0]),
        .wdata  (b0_wdata),
        .re0    (re0),
        .raddr0 (rd_addr0[AW-1:0]),
        .rdata0 (b0_rd0),
        .re1    (re1),
        .raddr1 (rd_addr1[AW-1:0]),
        .rdata1 (b0_rd1)
    );

    msk_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_bank1 (
        .clk    (clk),
        .we     (b1_we),
        .waddr  (k_reg[AW-1:0]),
        .wdata  (merge_data),
        .re0    (re0),
        .raddr0 (rd_addr0[AW-1:0]),
        .rdata0 (b1_rd0),
        .re1    (re1),
        .raddr1 (rd_addr1[AW-1:0]),
        .rdata1 (b1_rd1)
    );

    assign stat.trivial  = cnt_reg <= CW'(1);
    assign stat.run_end  = (SW'(k_reg) + SW'(1)) == SW'(hi_reg);
    assign stat.pass_end = hi_reg == cnt_reg;
    assign stat.sorted   = (width_w << 1) >= n_w;
    assign stat.out_done = ov_reg && out_ready && out_last_reg;

    always_comb
    begin
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        i_next       = i_reg;
        dv_next      = dv_reg;
        dv_last_next = dv_last_reg;
        ov_next      = ov_reg;

        if (cmd.load)
        begin
            if (load_wr)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.start)
        begin
            width_next = (CW+1)'(1);
            lo_next    = '0;
            src_next   = 1'b0;
        end
        if (cmd.prime)
        begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            a_next   = lo_reg;
            b_next   = mid_calc;
            k_next   = lo_reg;
        end
        if (cmd.merge)
        begin
            a_next = a_step;
            b_next = b_step;
            k_next = k_reg + CW'(1);
            if (stat.run_end)
            begin
                if (stat.pass_end)
                begin
                    lo_next    = '0;
                    width_next = width_reg << 1;
                    src_next   = !src_reg;
                end
                else
                begin
                    lo_next = hi_reg;
                end
            end
        end

        if (!cmd.out_run)
        begin
            i_next  = '0;
            dv_next = 1'b0;
        end
        else
        begin
            if (fetch)
            begin
                i_next       = i_reg + CW'(1);
                dv_last_next = (SW'(i_reg) + SW'(1)) == n_w;
            end
            dv_next = fetch || (dv_reg && !move);
        end
        if (move)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end

        if (cmd.done)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            width_reg   <= '0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            src_reg     <= 1'b0;
            i_reg       <= '0;
            dv_reg      <= 1'b0;
            dv_last_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            width_reg   <= width_next;
            lo_reg      <= lo_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            k_reg       <= k_next;
            src_reg     <= src_next;
            i_reg       <= i_next;
            dv_reg      <= dv_next;
            dv_last_reg <= dv_last_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_key_reg  <= head_a;
            out_last_reg <= dv_last_reg;
        end
    end

    assign out_valid           = ov_reg;
    assign out_item.sorted_key = $signed(out_key_reg);
    assign out_item.end_of_run = out_last_reg;
    assign out_item.truncated  = ovf_reg;

endmodule

@@ hw/rtl/merge_sort_keys_top.sv @@
// Loads one key per cycle; the last request starts the sort.
// Sort of n keys: a setup state, then ceil(log2 n) passes; each run of a pass fetches its
// heads, then takes one merge step per cycle through the two-read-port ping-pong key RAMs.
// Results stream one per cycle while out_ready is high, via the RAM read register and then the
// output register. Input is held off from the last request until the last result is taken.
// Reset (rst_n, async, active low) empties the set; no RAM clearing pass.
module merge_sort_keys_top import msk_pkg::*; #(
    parameter int MAX_KEYS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    msk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_item.last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msk_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_key    (in_item.key),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
